@@ hw/rtl/bts_pkg.sv @@
// ----------------------------------------------------------------------------
// Binary thinning sub-pass package
// Shared sizes, register indexes, the queue entry type and the thinning test.
// ----------------------------------------------------------------------------
package bts_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 4096;

  localparam int COL_W    = $clog2(MAX_WIDTH);
  localparam int WCLAMP_W = $clog2(MAX_WIDTH + 1);
  localparam int HCLAMP_W = $clog2(MAX_HEIGHT + 1);
  localparam int ROW_W    = $clog2(MAX_HEIGHT + 2);

  localparam int FW_W        = 12;
  localparam int FH_W        = 13;
  localparam int CFG_DATA_W  = 13;
  localparam int CFG_INDEX_W = 2;
  localparam int MIN_DIM     = 3;
  localparam int WIDTH_RESET  = 640;
  localparam int HEIGHT_RESET = 480;

  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PASS_PARITY  = 2'd2;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int WIN_W      = 9;
  localparam int WIN_CENTER = 4;
  localparam logic [WIN_W-1:0] WIN_KEEP_MASK = 9'h0DB;

  typedef struct packed {
    logic [WCLAMP_W-1:0] width;
    logic [HCLAMP_W-1:0] height;
    logic                parity;
  } cfg_t;

  typedef struct packed {
    logic [WIN_W-1:0] window;
    logic             interior;
    logic             last;
  } job_t;

  // Window layout: top row bits 0..2, middle 3..5, bottom 6..8, left to right.
  function automatic logic clears_pixel(input logic [WIN_W-1:0] w, input logic parity);
    logic p2, p3, p4, p5, p6, p7, p8, p9;
    logic [2:0] c, n1, n2, n;
    logic m;
    p9 = w[0];
    p2 = w[1];
    p3 = w[2];
    p8 = w[3];
    p4 = w[5];
    p7 = w[6];
    p6 = w[7];
    p5 = w[8];
    c  = {2'b00, ~p2 & (p3 | p4)} + {2'b00, ~p4 & (p5 | p6)}
       + {2'b00, ~p6 & (p7 | p8)} + {2'b00, ~p8 & (p9 | p2)};
    n1 = {2'b00, p9 | p2} + {2'b00, p3 | p4} + {2'b00, p5 | p6} + {2'b00, p7 | p8};
    n2 = {2'b00, p2 | p3} + {2'b00, p4 | p5} + {2'b00, p6 | p7} + {2'b00, p8 | p9};
    n  = (n1 < n2) ? n1 : n2;
    if (!parity) begin
      m = (p6 | p7 | ~p9) & p8;
    end else begin
      m = (p2 | p3 | ~p5) & p4;
    end
    return (c == 3'd1) && (n >= 3'd2) && (n <= 3'd3) && !m;
  endfunction

endpackage

@@ hw/rtl/bts_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bts_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/bts_fifo.sv @@
// ----------------------------------------------------------------------------
// Thinning job queue
// Short queue between the windowing front end and the decision back end.
// ----------------------------------------------------------------------------
module bts_fifo (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  input  bts_pkg::job_t             push_job,
  input  logic                      pop,
  output logic                      head_valid,
  output bts_pkg::job_t             head_job,
  output logic [bts_pkg::QCNT_W-1:0] count
);

  import bts_pkg::*;

  job_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;

  assign head_valid = (count != '0);
  assign head_job   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0)
    else $error("queue popped while empty");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |-> count < QCNT_W'(QUEUE_DEPTH))
    else $error("queue pushed while full");

endmodule

@@ hw/rtl/bts_front.sv @@
// ----------------------------------------------------------------------------
// Thinning front end
// Tracks raster position, keeps the line stores and the 3x3 window, and
// queues one job for every input transaction that yields a result.
// ----------------------------------------------------------------------------
module bts_front (
  input  logic                       clk,
  input  logic                       rst,
  input  bts_pkg::cfg_t              cfg,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       pixel_in,
  input  logic                       flush,
  input  logic [bts_pkg::QCNT_W-1:0] queue_count,
  output logic                       push,
  output bts_pkg::job_t              push_job
);

  import bts_pkg::*;

  localparam int CMP_W = WCLAMP_W + 1;

  logic [COL_W-1:0] in_column;
  logic [ROW_W-1:0] in_row;
  logic [WIN_W-1:0] window;
  logic [WIN_W-1:0] window_next;

  logic             a_valid;
  logic             a_px;
  logic             a_keep;
  logic             a_last;
  logic             a_interior;
  logic [COL_W-1:0] a_col;
  logic             a_byp;
  logic [1:0]       a_byp_data;

  logic             accept;
  logic             px;
  logic [CMP_W-1:0] col_inc;
  logic             col_wrap;
  logic [ROW_W:0]   row_e;
  logic [ROW_W:0]   height_e;
  logic             is_last;
  logic             is_keep;
  logic             is_interior;
  logic [1:0]       rdata;
  logic [1:0]       old_rows;
  logic [1:0]       wdata;

  assign in_ready = ((QCNT_W + 1)'(queue_count) + (QCNT_W + 1)'(a_valid))
                    < (QCNT_W + 1)'(QUEUE_DEPTH);
  assign accept   = in_valid && in_ready;
  assign px       = pixel_in & ~flush;

  assign col_inc     = CMP_W'(in_column) + CMP_W'(1);
  assign col_wrap    = col_inc >= CMP_W'(cfg.width);
  assign row_e       = (ROW_W + 1)'(in_row);
  assign height_e    = (ROW_W + 1)'(cfg.height);
  assign is_last     = row_e > height_e;
  assign is_keep     = (in_row >= ROW_W'(2)) || ((in_row == ROW_W'(1)) && (in_column != '0));
  assign is_interior = (in_column >= COL_W'(2)) && (in_row >= ROW_W'(2)) && (row_e < height_e);

  // Bit 1 holds the upper row store, bit 0 the middle row store.
  bts_ram #(
    .WIDTH(2),
    .DEPTH(MAX_WIDTH)
  ) u_rows (
    .clk  (clk),
    .we   (a_valid),
    .waddr(a_col),
    .wdata(wdata),
    .re   (accept),
    .raddr(in_column),
    .rdata(rdata)
  );

  assign old_rows = a_byp ? a_byp_data : rdata;
  assign wdata    = {old_rows[0], a_px};

  always_comb begin
    window_next    = (window >> 1) & WIN_KEEP_MASK;
    window_next[2] = old_rows[1];
    window_next[5] = old_rows[0];
    window_next[8] = a_px;
  end

  assign push     = a_valid && a_keep;
  assign push_job = '{window: window_next, interior: a_interior, last: a_last};

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      in_column <= '0;
      in_row    <= '0;
      window    <= '0;
    end else begin
      a_valid <= accept;
      if (accept) begin
        if (is_last) begin
          in_column <= '0;
          in_row    <= '0;
        end else if (col_wrap) begin
          in_column <= '0;
          in_row    <= in_row + 1'b1;
        end else begin
          in_column <= COL_W'(col_inc);
        end
      end
      if (a_valid) begin
        window <= window_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_px       <= px;
      a_keep     <= is_keep;
      a_last     <= is_last;
      a_interior <= is_interior;
      a_col      <= in_column;
      a_byp      <= a_valid && (a_col == in_column);
      a_byp_data <= wdata;
    end
  end

  a_stage_from_accept: assert property (@(posedge clk) disable iff (rst)
    a_valid |-> $past(accept))
    else $error("window stage active without an accepted transaction");

  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    (accept && is_last) |=> (in_column == '0) && (in_row == '0))
    else $error("position not restarted after the last transaction of a frame");

  a_queue_room: assert property (@(posedge clk) disable iff (rst)
    push |-> queue_count < QCNT_W'(QUEUE_DEPTH))
    else $error("job pushed without reserved queue space");

endmodule

@@ hw/rtl/bts_back.sv @@
// ----------------------------------------------------------------------------
// Thinning back end
// Applies the sub-pass deletion test to queued jobs and holds the result
// in the output register until the downstream side takes it.
// ----------------------------------------------------------------------------
module bts_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          parity,
  input  logic          head_valid,
  input  bts_pkg::job_t head_job,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic          pixel_out,
  output logic          frame_end
);

  import bts_pkg::*;

  logic load;
  logic center;
  logic result;

  assign load   = !out_valid || out_ready;
  assign pop    = head_valid && load;
  assign center = head_job.window[WIN_CENTER];
  assign result = center && !(head_job.interior && clears_pixel(head_job.window, parity));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      pixel_out <= result;
      frame_end <= head_job.last;
    end
  end

  a_pop_fills: assert property (@(posedge clk) disable iff (rst)
    pop |=> out_valid)
    else $error("popped job did not reach the output register");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !pop)
    else $error("pending result overwritten");

endmodule

@@ hw/rtl/binary_thinning_subpass_top.sv @@
// Each result passes through the window stage and the job queue into the output
// register; the first width+1 transactions of a frame cause none. Throughput:
// one transaction per cycle while in_ready is high, set by the single read
// and write per cycle of the shared line-store RAM.
// Reset clears position counters, window, queue and output valid; the line
// stores are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// Binary thinning sub-pass top level
// One Guo-Hall sub-iteration over a raster pixel stream with a config port.
// ----------------------------------------------------------------------------
module binary_thinning_subpass_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            pixel_in,
  input  logic                            flush,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            pixel_out,
  output logic                            frame_end,
  input  logic                            cfg_we,
  input  logic [bts_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [bts_pkg::CFG_DATA_W-1:0]  cfg_data
);

  import bts_pkg::*;

  cfg_t                cfg;
  logic [FW_W-1:0]     width_raw;
  logic [FH_W-1:0]     height_raw;
  logic [WCLAMP_W-1:0] width_clamped;
  logic [HCLAMP_W-1:0] height_clamped;

  logic                push;
  job_t                push_job;
  logic                pop;
  logic                head_valid;
  job_t                head_job;
  logic [QCNT_W-1:0]   queue_count;

  assign width_raw  = cfg_data[FW_W-1:0];
  assign height_raw = cfg_data[FH_W-1:0];

  always_comb begin
    if (width_raw < FW_W'(MIN_DIM)) begin
      width_clamped = WCLAMP_W'(MIN_DIM);
    end else if (int'(width_raw) > MAX_WIDTH) begin
      width_clamped = WCLAMP_W'(MAX_WIDTH);
    end else begin
      width_clamped = WCLAMP_W'(width_raw);
    end
    if (height_raw < FH_W'(MIN_DIM)) begin
      height_clamped = HCLAMP_W'(MIN_DIM);
    end else if (int'(height_raw) > MAX_HEIGHT) begin
      height_clamped = HCLAMP_W'(MAX_HEIGHT);
    end else begin
      height_clamped = HCLAMP_W'(height_raw);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.width  <= WCLAMP_W'(WIDTH_RESET);
      cfg.height <= HCLAMP_W'(HEIGHT_RESET);
      cfg.parity <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  cfg.width  <= width_clamped;
        REG_FRAME_HEIGHT: cfg.height <= height_clamped;
        REG_PASS_PARITY:  cfg.parity <= cfg_data[0];
        default: ;
      endcase
    end
  end

  bts_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .pixel_in   (pixel_in),
    .flush      (flush),
    .queue_count(queue_count),
    .push       (push),
    .push_job   (push_job)
  );

  bts_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .pop       (pop),
    .head_valid(head_valid),
    .head_job  (head_job),
    .count     (queue_count)
  );

  bts_back u_back (
    .clk       (clk),
    .rst       (rst),
    .parity    (cfg.parity),
    .head_valid(head_valid),
    .head_job  (head_job),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .pixel_out (pixel_out),
    .frame_end (frame_end)
  );

endmodule
